// ----- rtl/jsu_pkg.sv -----
// jsu_pkg: types, constants and helper functions of the json string unescaper
// no dependencies; used by every module of the block but jsu_checker
`default_nettype none

package jsu_pkg;

    // decoder modes, one-hot
    typedef enum logic [5:0] {
        MODE_NORMAL = 6'b000001,
        MODE_ESC    = 6'b000010,
        MODE_HEX8   = 6'b000100,
        MODE_HIGH   = 6'b001000,
        MODE_SKIP   = 6'b010000,
        MODE_LOW    = 6'b100000
    } t_mode;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6e;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;

    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0c;
    localparam logic [7:0] CTL_LF = 8'h0a;
    localparam logic [7:0] CTL_CR = 8'h0d;
    localparam logic [7:0] CTL_TAB = 8'h09;

    localparam logic [15:0] SURR_LO = 16'hd800;
    localparam logic [15:0] SURR_HI = 16'hdfff;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // one record: up to four output bytes for one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt;      // number of bytes minus one
        logic            str_end;
    } t_rec;

    // hex digit by the low five bits of the byte; unmapped codes give 0
    function automatic logic [3:0] hex_digit(input logic [4:0] idx);
        logic [3:0] v;
        v = 4'd0;
        if (idx >= 5'd1 && idx <= 5'd6) begin
            v = 4'(idx + 5'd9);
        end else if (idx >= 5'd16 && idx <= 5'd25) begin
            v = 4'(idx - 5'd16);
        end
        return v;
    endfunction

    function automatic t_rec byte_rec(input logic [7:0] b, input logic str_end);
        t_rec r;
        r = '0;
        r.bytes[0] = b;
        r.str_end = str_end;
        return r;
    endfunction

    function automatic t_rec utf8_rec(input logic [20:0] cp);
        t_rec r;
        r = '0;
        if (cp <= 21'h7f) begin
            r.bytes[0] = cp[7:0];
            r.cnt = 2'd0;
        end else if (cp <= 21'h7ff) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.cnt = 2'd1;
        end else if (cp <= 21'hffff) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.cnt = 2'd2;
        end else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.cnt = 2'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/jsu_front.sv -----
// jsu_front: escape decoder; takes one input byte per word, keeps the escape
// state and builds one output record per byte that yields bytes; uses jsu_pkg
`default_nettype none

module jsu_front
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_take,
    input  wire logic [7:0] i_in_byte,
    output t_rec            o_rec,
    output logic            o_rec_vld
);

    t_mode       r_mode, n_mode;
    logic [1:0]  r_dcnt, n_dcnt;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;

    logic [3:0]  d;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    logic [20:0] pair_cp;

    assign d = hex_digit(i_in_byte[4:0]);
    assign hi_unit = {r_first[11:0], d};
    assign lo_unit = {r_second[11:0], d};
    assign pair_cp = SUPP_BASE + {1'b0, r_first[9:0], lo_unit[9:0]};

    always_comb begin
        n_mode = r_mode;
        n_dcnt = r_dcnt;
        n_first = r_first;
        n_second = r_second;
        o_rec = '0;
        o_rec_vld = 1'b0;
        case (r_mode)
            MODE_ESC: begin
                n_mode = MODE_NORMAL;
                if (i_in_byte == CH_X) begin
                    n_mode = MODE_HEX8;
                    n_dcnt = 2'd0;
                    n_first = '0;
                end else if (i_in_byte == CH_U) begin
                    n_mode = MODE_HIGH;
                    n_dcnt = 2'd0;
                    n_first = '0;
                end else begin
                    o_rec_vld = 1'b1;
                    if (i_in_byte == CH_B) o_rec = byte_rec(CTL_BS, 1'b0);
                    else if (i_in_byte == CH_F) o_rec = byte_rec(CTL_FF, 1'b0);
                    else if (i_in_byte == CH_N) o_rec = byte_rec(CTL_LF, 1'b0);
                    else if (i_in_byte == CH_R) o_rec = byte_rec(CTL_CR, 1'b0);
                    else if (i_in_byte == CH_T) o_rec = byte_rec(CTL_TAB, 1'b0);
                    else o_rec = byte_rec(i_in_byte, 1'b0);
                end
            end
            MODE_HEX8: begin
                n_first = {8'h00, r_first[3:0], d};
                if (r_dcnt != 2'd0) begin
                    n_dcnt = 2'd0;
                    n_mode = MODE_NORMAL;
                    o_rec_vld = 1'b1;
                    o_rec = byte_rec({r_first[3:0], d}, 1'b0);
                end else begin
                    n_dcnt = r_dcnt + 2'd1;
                end
            end
            MODE_HIGH: begin
                n_first = hi_unit;
                if (r_dcnt == 2'd3) begin
                    n_dcnt = 2'd0;
                    if (hi_unit < SURR_LO || hi_unit > SURR_HI) begin
                        n_mode = MODE_NORMAL;
                        o_rec_vld = 1'b1;
                        o_rec = utf8_rec({5'd0, hi_unit});
                    end else begin
                        n_mode = MODE_SKIP;
                    end
                end else begin
                    n_dcnt = r_dcnt + 2'd1;
                end
            end
            MODE_SKIP: begin
                // the two bytes between the units are dropped unchecked
                if (r_dcnt != 2'd0) begin
                    n_dcnt = 2'd0;
                    n_second = '0;
                    n_mode = MODE_LOW;
                end else begin
                    n_dcnt = r_dcnt + 2'd1;
                end
            end
            MODE_LOW: begin
                n_second = lo_unit;
                if (r_dcnt == 2'd3) begin
                    n_dcnt = 2'd0;
                    n_mode = MODE_NORMAL;
                    o_rec_vld = 1'b1;
                    o_rec = utf8_rec(pair_cp);
                end else begin
                    n_dcnt = r_dcnt + 2'd1;
                end
            end
            default: begin
                n_mode = MODE_NORMAL;
                if (i_in_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else if (i_in_byte == CH_QUOTE || i_in_byte == CH_NUL) begin
                    n_dcnt = 2'd0;
                    o_rec_vld = 1'b1;
                    o_rec = byte_rec(8'h00, 1'b1);
                end else begin
                    o_rec_vld = 1'b1;
                    o_rec = byte_rec(i_in_byte, 1'b0);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_dcnt <= '0;
            r_first <= '0;
            r_second <= '0;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_dcnt <= n_dcnt;
            r_first <= n_first;
            r_second <= n_second;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_fifo.sv -----
// jsu_fifo: short record queue between the decoder and the byte serializer
// uses jsu_pkg for the record type
`default_nettype none

module jsu_fifo
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_rec      i_wr_rec,
    input  wire logic i_rd,
    output t_rec      o_head,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_rec          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_wr, do_rd;

    assign o_full = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head = r_mem[r_rd];
    assign do_wr = i_wr && !o_full;
    assign do_rd = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr] <= i_wr_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_rd) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/jsu_back.sv -----
// jsu_back: serializer; walks the bytes of the head record one per popped word
// and retires the record after its last byte; uses jsu_pkg
`default_nettype none

module jsu_back
    import jsu_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_rec            i_head,
    input  wire logic       i_head_vld,
    input  wire logic       i_pop,
    output logic            o_retire,
    output logic [7:0]      o_out_byte,
    output logic            o_string_end,
    output logic            o_last
);

    logic [1:0] r_idx;
    logic       take;

    assign o_out_byte = i_head.bytes[r_idx];
    assign o_string_end = i_head.str_end;
    assign o_last = (r_idx == i_head.cnt);
    assign take = i_pop && i_head_vld;
    assign o_retire = take && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (take) begin
            r_idx <= o_last ? 2'd0 : r_idx + 2'd1;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_unit.sv -----
// json_string_unescape_unit: json string body unescaper, top level
// uses jsu_pkg, jsu_front, jsu_fifo, jsu_back
//
// input side is a queue: drive i_in_byte and raise push; the word is taken on
// a rising edge where push is high and full is low. the bytes are the string
// body after the opening quote. output side is a queue too: while empty is
// low the oldest output byte is on o_out_byte with o_string_end and o_last,
// and raising pop takes it on that edge.
// every input byte is decoded in the cycle it is taken; bytes that yield
// output leave a record of one to four bytes in a DEPTH-entry queue. the
// first output byte of a word shows at the earliest in the cycle after it is
// taken. input runs at one byte per cycle while full is low; the serializer
// gives one output byte per cycle while pop is high, so a word that expands
// to n bytes holds the serializer until its n bytes are popped, and full
// rises once DEPTH records are queued, the one being serialized included.
// reset (synchronous, active low) returns the decoder to normal copy mode
// and empties the queue. if the receiver stops popping, records pile up and
// full is raised; nothing is dropped.
`default_nettype none

module json_string_unescape_unit
    import jsu_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_out_byte,
    output logic            o_string_end,
    output logic            o_last
);

    t_rec rec;
    logic rec_vld;
    t_rec head;
    logic retire;
    logic take;

    assign take = push && !full;

    jsu_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_in_byte (i_in_byte),
        .o_rec     (rec),
        .o_rec_vld (rec_vld)
    );

    jsu_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (take && rec_vld),
        .i_wr_rec (rec),
        .i_rd     (retire),
        .o_head   (head),
        .o_full   (full),
        .o_empty  (empty)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_vld   (!empty),
        .i_pop        (pop),
        .o_retire     (retire),
        .o_out_byte   (o_out_byte),
        .o_string_end (o_string_end),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

// ----- rtl/jsu_checker.sv -----
// jsu_checker: port-level checks of json_string_unescape_unit, bound to the top
// no package needed; watches the top level ports only
`default_nettype none

module jsu_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_string_end,
    input wire logic       o_last
);

    // reset leaves the queue empty and open for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queue not clear after reset");

    // a terminator is a lone zero byte
    a_term_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_string_end |-> o_out_byte == 8'h00 && o_last)
        else $error("terminator word is not a lone zero byte");

    // a multi-byte sequence keeps going after a non-final byte is popped
    a_seq_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && pop && !o_last |=> !empty && !o_string_end)
        else $error("utf-8 sequence cut short");

    // a waiting word holds while not popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_byte) && $stable(o_last))
        else $error("waiting output word changed");

endmodule

bind json_string_unescape_unit jsu_checker u_jsu_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .push         (push),
    .full         (full),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_string_end (o_string_end),
    .o_last       (o_last)
);

`default_nettype wire

// ----- test/unescape_tb_pkg.sv -----
`timescale 1ns / 100ps
// unescape_tb_pkg: scoreboard for the json string unescaper testbench
// keeps its own copy of the decoder state and the words still owed by the block
// depends on jsu_pkg for the mode encoding and the character constants

package unescape_tb_pkg;

    import jsu_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       str_end;
        logic       last;
    } t_out_word;

    class unescape_scoreboard;
        t_mode      mode;
        logic [1:0] digits;
        logic [15:0] hi_unit;
        logic [15:0] lo_unit;
        t_out_word  expected_q[$];
        int         errors;

        function new();
            mode = MODE_NORMAL;
            digits = 2'd0;
            hi_unit = 16'h0000;
            lo_unit = 16'h0000;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // value of a hex digit by the low five bits, anything else reads as zero
        function logic [3:0] nibble_of(logic [7:0] b);
            if (b[4:0] >= 5'd1 && b[4:0] <= 5'd6) begin
                return 4'(b[4:0] + 5'd9);
            end
            if (b[4:0] >= 5'd16 && b[4:0] <= 5'd25) begin
                return 4'(b[4:0] - 5'd16);
            end
            return 4'd0;
        endfunction

        function void add_word(logic [7:0] data, logic str_end);
            t_out_word w;
            w.data = data;
            w.str_end = str_end;
            w.last = 1'b0;
            expected_q.push_back(w);
        endfunction

        function void add_code_point(logic [20:0] cp);
            if (cp < 21'h80) begin
                add_word(cp[7:0], 1'b0);
            end else if (cp < 21'h800) begin
                add_word({3'b110, cp[10:6]}, 1'b0);
                add_word({2'b10, cp[5:0]}, 1'b0);
            end else if (cp < 21'h10000) begin
                add_word({4'b1110, cp[15:12]}, 1'b0);
                add_word({2'b10, cp[11:6]}, 1'b0);
                add_word({2'b10, cp[5:0]}, 1'b0);
            end else begin
                add_word({5'b11110, cp[20:18]}, 1'b0);
                add_word({2'b10, cp[17:12]}, 1'b0);
                add_word({2'b10, cp[11:6]}, 1'b0);
                add_word({2'b10, cp[5:0]}, 1'b0);
            end
        endfunction

        function void note_input(logic [7:0] b);
            int          prev_size;
            logic [3:0]  nib;
            logic [20:0] cp;
            prev_size = expected_q.size();
            nib = nibble_of(b);
            case (mode)
                MODE_ESC: begin
                    mode = MODE_NORMAL;
                    if (b == CH_X) begin
                        mode = MODE_HEX8;
                        digits = 2'd0;
                        hi_unit = 16'h0000;
                    end else if (b == CH_U) begin
                        mode = MODE_HIGH;
                        digits = 2'd0;
                        hi_unit = 16'h0000;
                    end else begin
                        case (b)
                            CH_B: add_word(CTL_BS, 1'b0);
                            CH_F: add_word(CTL_FF, 1'b0);
                            CH_N: add_word(CTL_LF, 1'b0);
                            CH_R: add_word(CTL_CR, 1'b0);
                            CH_T: add_word(CTL_TAB, 1'b0);
                            default: add_word(b, 1'b0);
                        endcase
                    end
                end
                MODE_HEX8: begin
                    hi_unit = {8'h00, hi_unit[3:0], nib};
                    if (digits != 2'd0) begin
                        digits = 2'd0;
                        mode = MODE_NORMAL;
                        add_word(hi_unit[7:0], 1'b0);
                    end else begin
                        digits++;
                    end
                end
                MODE_HIGH: begin
                    hi_unit = {hi_unit[11:0], nib};
                    if (digits == 2'd3) begin
                        digits = 2'd0;
                        if (hi_unit < SURR_LO || hi_unit > SURR_HI) begin
                            mode = MODE_NORMAL;
                            add_code_point({5'd0, hi_unit});
                        end else begin
                            mode = MODE_SKIP;
                        end
                    end else begin
                        digits++;
                    end
                end
                MODE_SKIP: begin
                    // the two bytes between the units are dropped unchecked
                    if (digits != 2'd0) begin
                        digits = 2'd0;
                        lo_unit = 16'h0000;
                        mode = MODE_LOW;
                    end else begin
                        digits++;
                    end
                end
                MODE_LOW: begin
                    lo_unit = {lo_unit[11:0], nib};
                    if (digits == 2'd3) begin
                        digits = 2'd0;
                        mode = MODE_NORMAL;
                        cp = SUPP_BASE + {1'b0, hi_unit[9:0], lo_unit[9:0]};
                        add_code_point(cp);
                    end else begin
                        digits++;
                    end
                end
                default: begin
                    mode = MODE_NORMAL;
                    if (b == CH_BSLASH) begin
                        mode = MODE_ESC;
                    end else if (b == CH_QUOTE || b == CH_NUL) begin
                        digits = 2'd0;
                        add_word(8'h00, 1'b1);
                    end else begin
                        add_word(b, 1'b0);
                    end
                end
            endcase
            if (expected_q.size() > prev_size) begin
                expected_q[expected_q.size() - 1].last = 1'b1;
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(logic [7:0] data, logic str_end, logic last);
            t_out_word w;
            if (expected_q.size() == 0) begin
                report($sformatf("word %02h arrived with nothing owed", data));
                return;
            end
            w = expected_q.pop_front();
            if (data !== w.data) begin
                report($sformatf("out_byte %02h, wanted %02h", data, w.data));
            end
            if (str_end !== w.str_end) begin
                report($sformatf("string_end %b, wanted %b (byte %02h)", str_end, w.str_end,
                                 w.data));
            end
            if (last !== w.last) begin
                report($sformatf("last %b, wanted %b (byte %02h)", last, w.last, w.data));
            end
        endtask

        task check_drained();
            if (expected_q.size() != 0) begin
                report($sformatf("%0d words never arrived", expected_q.size()));
            end
        endtask
    endclass

endpackage

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// tb_top: testbench for json_string_unescape_unit, directed escapes then random strings
// depends on jsu_pkg, unescape_tb_pkg and the rtl of the block

module tb_top;

    import jsu_pkg::*;
    import unescape_tb_pkg::*;

    localparam int RANDOM_ITEMS = 228;
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       pop = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       full;
    logic       empty;
    logic [7:0] o_out_byte;
    logic       o_string_end;
    logic       o_last;

    unescape_scoreboard sb = new();
    logic [7:0] stim_q[$];
    int         taken_in = 0;
    int         quiet = 0;
    bit         calm = 1'b0;
    bit         held = 1'b0;

    json_string_unescape_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_byte   (i_in_byte),
        .empty       (empty),
        .pop         (pop),
        .o_out_byte  (o_out_byte),
        .o_string_end(o_string_end),
        .o_last      (o_last)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // stretches where neither side idles
    initial forever begin
        repeat ($urandom_range(40, 160)) @(posedge i_clk);
        calm = ($urandom_range(0, 3) == 0);
    end

    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void add_str(string s);
        foreach (s[i]) stim_q.push_back(s[i]);
    endfunction

    // a digit byte with random upper bits, decoded by its low five bits
    function automatic void add_hex(logic [3:0] v);
        logic [4:0] idx;
        idx = (v < 4'd10) ? 5'(v + 5'd16) : 5'(v - 4'd9);
        stim_q.push_back({3'($urandom_range(0, 7)), idx});
    endfunction

    function automatic void add_unit(logic [15:0] v);
        add_hex(v[15:12]);
        add_hex(v[11:8]);
        add_hex(v[7:4]);
        add_hex(v[3:0]);
    endfunction

    function automatic void add_pair_tail();
        stim_q.push_back(8'($urandom_range(0, 255)));
        stim_q.push_back(8'($urandom_range(0, 255)));
        add_unit(16'($urandom_range(0, 16'hffff)));
    endfunction

    function automatic void add_random_seq();
        logic [7:0]  esc_letters[5];
        logic [7:0]  b;
        logic [15:0] u;
        int          r;
        esc_letters = '{CH_B, CH_F, CH_N, CH_R, CH_T};
        r = $urandom_range(0, 99);
        if (r < 30) begin
            repeat ($urandom_range(1, 6)) begin
                b = 8'($urandom_range(1, 255));
                if (b == CH_BSLASH || b == CH_QUOTE) b = 8'h61;
                stim_q.push_back(b);
            end
        end else if (r < 40) begin
            stim_q.push_back($urandom_range(0, 1) ? CH_QUOTE : CH_NUL);
        end else if (r < 55) begin
            stim_q.push_back(CH_BSLASH);
            if ($urandom_range(0, 1)) begin
                stim_q.push_back(esc_letters[$urandom_range(0, 4)]);
            end else begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_X || b == CH_U) b = CH_BSLASH;
                stim_q.push_back(b);
            end
        end else if (r < 65) begin
            stim_q.push_back(CH_BSLASH);
            stim_q.push_back(CH_X);
            add_hex(4'($urandom_range(0, 15)));
            add_hex(4'($urandom_range(0, 15)));
        end else if (r < 80) begin
            case ($urandom_range(0, 2))
                0: u = 16'($urandom_range(0, 16'h7f));
                1: u = 16'($urandom_range(16'h80, 16'h7ff));
                default: u = 16'($urandom_range(16'h800, 16'hffff));
            endcase
            stim_q.push_back(CH_BSLASH);
            stim_q.push_back(CH_U);
            add_unit(u);
            if (u >= SURR_LO && u <= SURR_HI) add_pair_tail();
        end else if (r < 90) begin
            stim_q.push_back(CH_BSLASH);
            stim_q.push_back(CH_U);
            add_unit(16'($urandom_range(SURR_LO, SURR_HI)));
            add_pair_tail();
        end else begin
            // noise, may break off an escape half way
            repeat ($urandom_range(1, 4)) stim_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic drive_byte(input logic [7:0] b);
        push <= 1'b1;
        i_in_byte <= b;
        do @(posedge i_clk); while (full);
        sb.note_input(b);
        taken_in++;
        @(negedge i_clk);
    endtask

    // receiver: random pop gaps, one long hold-off to fill the block
    initial begin
        int g;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && taken_in >= 60) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                g = idle_len();
                if (g > 0) begin
                    pop <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_out_byte, o_string_end, o_last);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("json_string_unescape_unit regression: fail");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        int n_dir;
        int g;
        stim_q.push_back(8'h01);
        stim_q.push_back(8'hff);
        add_str("\\n\\\"");
        stim_q.push_back(CH_BSLASH);
        stim_q.push_back(CH_NUL);
        add_str("\\xfF");
        // digit byte outside the table reads as zero
        add_str("\\uz041");
        add_str("\\ud83d\\ude00");
        stim_q.push_back(CH_QUOTE);
        stim_q.push_back(CH_NUL);
        n_dir = stim_q.size();
        while (stim_q.size() < n_dir + RANDOM_ITEMS) add_random_seq();

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (stim_q[i]) begin
            g = idle_len();
            if (g > 0) begin
                push <= 1'b0;
                repeat (g) @(negedge i_clk);
            end
            drive_byte(stim_q[i]);
        end
        push <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("json_string_unescape_unit regression: pass");
        end else begin
            $display("json_string_unescape_unit regression: fail");
        end
        $finish;
    end

endmodule
